@@ rtl/substring_highlight_segmenter_unit_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef SUBSTRING_HIGHLIGHT_SEGMENTER_UNIT_MACROS_SVH
`define SUBSTRING_HIGHLIGHT_SEGMENTER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SHS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shs assertion failed");

// Antecedent implies consequent in the next cycle.
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`endif

@@ rtl/shs_pkg.sv @@
package shs_pkg;

  localparam int unsigned POS_W       = 16;
  localparam int unsigned SEG_W       = POS_W + 1;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned MAX_LINE    = 65535;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned NUM_SEG     = 5;
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_PAT_LEN = 3'd2,
    CFG_CASE    = 3'd3,
    CFG_WORD    = 3'd4,
    CFG_ENABLE  = 3'd5
  } cfg_idx_e;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [LEN_W-1:0] len_t;

  // Events of one accepted byte, handed from the front to the back.
  typedef struct packed {
    seg_t sb0;         // segment begin before this byte
    seg_t sb1;         // segment begin after the pending match, if any
    pos_t pend_start;
    pos_t hit_start;
    pos_t line_stop;   // saturated end of line
    len_t pat_len;
    logic pend_emit;
    logic hit_emit;
    logic line_end;
  } shs_rec_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
    if (!exact && c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [15:0] clip16(input seg_t v);
    return (v > seg_t'(16'hffff)) ? 16'hffff : v[15:0];
  endfunction

endpackage

@@ rtl/substring_highlight_segmenter_unit.sv @@
// Splits a text line, one byte per beat, into unmatched and matched segments for a
// configured literal pattern of up to MAX_PATTERN bytes (leftmost, non-overlapping,
// optional ASCII case folding and whole-word rule). A byte is taken every cycle while
// the queue has room: all pattern lanes compare in parallel against a shift window in
// the front, which also keeps the line state. Bytes that produce results leave a record
// in a 4-entry queue; the back expands a record into one to three segment beats at one
// beat per cycle unless the output stalls, so input runs at one byte per cycle while
// results average at most one per cycle, and the queue absorbs bursts. Result beats are
// registered. In whole-word mode a match is reported with the following byte (or at
// line end). m_axis_tlast marks the last segment of a line; tuser[1] marks the last
// beat of a byte. Configuration is taken whenever offered (cfg_ready_o is always high)
// and should only be written while the block is idle.
module substring_highlight_segmenter_unit #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  logic                           s_axis_tlast,   // line_end
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,   // [15:0] segment_start,
                                                         // [31:16] segment_length
  output logic [1:0]                     m_axis_tuser,   // [0] is_match, [1] last
  output logic                           m_axis_tlast    // line_final
);
  import shs_pkg::*;

  shs_rec_t push_rec, head_rec;
  logic     push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  shs_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .text_byte_i (s_axis_tdata),
    .line_end_i  (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  shs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rec_o   (head_rec)
  );

  shs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .rec_i     (head_rec),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

@@ rtl/shs_front.sv @@
module shs_front #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           line_end_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output shs_pkg::shs_rec_t              rec_o
);
  import shs_pkg::*;

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  len_t                  pat_len_q;
  logic                  case_q, word_q, en_q;

  logic [7:0] win_q [MAX_PATTERN];
  logic [7:0] win_new [MAX_PATTERN+1];
  pos_t       pos_q, pos_d, nss_q, nss_d, pend_start_q, pend_start_d;
  seg_t       sb_q, sb_d, sb1;
  logic       pend_q, pend_d;

  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [MAX_PATTERN-1:0]  lane_ok;
  logic [7:0]              left_byte;
  len_t                    len;
  logic [POS_W:0]          next_pos;
  pos_t                    p, line_stop;
  logic                    accept, in_range, hit, left_ok, pend_emit, hit_emit;
  logic                    pend_set, trail;

  assign pat_all = {pat_hi_q, pat_lo_q};

  always_comb begin
    if (pat_len_q == '0) begin
      len = len_t'(1);
    end else if (int'(pat_len_q) > MAX_PATTERN) begin
      len = len_t'(MAX_PATTERN);
    end else begin
      len = pat_len_q;
    end
  end

  always_comb begin
    win_new[0] = text_byte_i;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      win_new[j+1] = win_q[j];
    end
  end

  // Lane j holds the byte that lines up with pattern byte len-1-j.
  always_comb begin
    len_t k;
    logic [7:0] pb;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      k  = len_t'(int'(len) - 1 - j);
      pb = k[LEN_W-1] ? 8'h00 : pat_all[{k[LEN_W-2:0], 3'b000} +: 8];
      if (j >= int'(len)) begin
        lane_ok[j] = 1'b1;
      end else begin
        lane_ok[j] = fold(win_new[j], case_q) == fold(pb, case_q);
      end
    end
  end

  always_comb begin
    left_byte = 8'h00;
    for (int j = 0; j <= MAX_PATTERN; j++) begin
      if (j == int'(len)) begin
        left_byte = win_new[j];
      end
    end
  end

  assign next_pos  = {1'b0, pos_q} + 1'b1;
  assign in_range  = (pos_q < pos_t'(MAX_LINE)) && (next_pos >= (POS_W+1)'(len));
  assign p         = pos_t'(next_pos - (POS_W+1)'(len));
  assign hit       = in_range && (p >= nss_q) && (&lane_ok);
  assign left_ok   = (p == '0) || !is_alnum(left_byte);
  assign pend_emit = pend_q && !is_alnum(text_byte_i);
  assign sb1       = pend_emit ? seg_t'(pend_start_q) + seg_t'(len) : sb_q;
  assign hit_emit  = hit && (!word_q || (left_ok && line_end_i));
  assign pend_set  = hit && word_q && left_ok && !line_end_i;
  assign line_stop = (next_pos > (POS_W+1)'(MAX_LINE)) ? pos_t'(MAX_LINE)
                                                        : next_pos[POS_W-1:0];
  assign trail     = line_end_i && !hit_emit && (seg_t'(line_stop) > sb1);

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = accept && en_q && (pend_emit || hit_emit || trail);

  assign rec_o.sb0        = sb_q;
  assign rec_o.sb1        = sb1;
  assign rec_o.pend_start = pend_start_q;
  assign rec_o.hit_start  = p;
  assign rec_o.line_stop  = line_stop;
  assign rec_o.pat_len    = len;
  assign rec_o.pend_emit  = pend_emit;
  assign rec_o.hit_emit   = hit_emit;
  assign rec_o.line_end   = line_end_i;

  always_comb begin
    pos_d        = line_end_i ? '0 : line_stop;
    nss_d        = line_end_i ? '0 : (hit ? next_pos[POS_W-1:0] : nss_q);
    sb_d         = line_end_i ? '0 : (hit_emit ? seg_t'(next_pos) : sb1);
    pend_d       = pend_set;
    pend_start_d = pend_set ? p : pend_start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= len_t'(1);
      case_q    <= 1'b0;
      word_q    <= 1'b0;
      en_q      <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        CFG_PAT_LEN: pat_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_CASE:    case_q    <= cfg_data_i[0];
        CFG_WORD:    word_q    <= cfg_data_i[0];
        CFG_ENABLE:  en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= 8'h00;
      end
      pos_q        <= '0;
      nss_q        <= '0;
      sb_q         <= '0;
      pend_q       <= 1'b0;
      pend_start_q <= '0;
    end else if (accept) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= line_end_i ? 8'h00 : win_new[j];
      end
      pos_q        <= pos_d;
      nss_q        <= nss_d;
      sb_q         <= sb_d;
      pend_q       <= pend_d;
      pend_start_q <= pend_start_d;
    end
  end

endmodule

@@ rtl/shs_queue.sv @@
module shs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  shs_pkg::shs_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output shs_pkg::shs_rec_t rec_o
);
  import shs_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  shs_rec_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/shs_back.sv @@
module shs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  shs_pkg::shs_rec_t rec_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [31:0]       m_data_o,
  output logic [1:0]        m_user_o,
  output logic              m_last_o
);
  import shs_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_SEG);
  localparam int unsigned RC_W  = $clog2(MAX_RES);
  // Slots in line order: gap, pending match, gap, new match, trailing text.
  localparam logic [NUM_SEG-1:0] MATCH_MASK = 5'b01010;

  seg_t               seg_start_q [NUM_SEG];
  seg_t               seg_len_q   [NUM_SEG];
  seg_t               new_start   [NUM_SEG];
  seg_t               new_len     [NUM_SEG];
  logic [NUM_SEG-1:0] vld_q, vld_d, new_vld, remaining;
  logic [RC_W-1:0]    cnt_q, cnt_d;
  logic               le_q;
  logic [IDX_W-1:0]   idx;
  logic               busy, out_free, emit, last, load;
  seg_t               sb2;

  logic               out_valid_q;
  logic [31:0]        out_data_q;
  logic [1:0]         out_user_q;
  logic               out_last_q;

  always_comb begin
    sb2 = rec_i.hit_emit ? seg_t'(rec_i.hit_start) + seg_t'(rec_i.pat_len) : rec_i.sb1;

    new_vld[0]   = rec_i.pend_emit && (seg_t'(rec_i.pend_start) > rec_i.sb0);
    new_start[0] = rec_i.sb0;
    new_len[0]   = seg_t'(rec_i.pend_start) - rec_i.sb0;

    new_vld[1]   = rec_i.pend_emit;
    new_start[1] = seg_t'(rec_i.pend_start);
    new_len[1]   = seg_t'(rec_i.pat_len);

    new_vld[2]   = rec_i.hit_emit && (seg_t'(rec_i.hit_start) > rec_i.sb1);
    new_start[2] = rec_i.sb1;
    new_len[2]   = seg_t'(rec_i.hit_start) - rec_i.sb1;

    new_vld[3]   = rec_i.hit_emit;
    new_start[3] = seg_t'(rec_i.hit_start);
    new_len[3]   = seg_t'(rec_i.pat_len);

    new_vld[4]   = rec_i.line_end && (seg_t'(rec_i.line_stop) > sb2);
    new_start[4] = sb2;
    new_len[4]   = seg_t'(rec_i.line_stop) - sb2;
  end

  always_comb begin
    idx = '0;
    for (int j = NUM_SEG - 1; j >= 0; j--) begin
      if (vld_q[j]) begin
        idx = IDX_W'(j);
      end
    end
  end

  assign remaining = vld_q & ~(NUM_SEG'(1) << idx);
  assign last      = (remaining == '0) || (cnt_q == RC_W'(MAX_RES - 1));
  assign busy      = |vld_q;
  assign out_free  = !out_valid_q || m_ready_i;
  assign emit      = busy && out_free;
  assign load      = (!busy || (emit && last)) && !empty_i;
  assign pop_o     = load;

  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    if (load) begin
      vld_d = new_vld;
      cnt_d = '0;
    end else if (emit) begin
      vld_d = last ? '0 : remaining;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int j = 0; j < NUM_SEG; j++) begin
        seg_start_q[j] <= new_start[j];
        seg_len_q[j]   <= new_len[j];
      end
      le_q <= rec_i.line_end;
    end
    if (emit) begin
      out_data_q <= {clip16(seg_len_q[idx]), clip16(seg_start_q[idx])};
      out_user_q <= {last, MATCH_MASK[idx]};
      out_last_q <= last && le_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = out_user_q;
  assign m_last_o  = out_last_q;

endmodule

@@ rtl/shs_checker.sv @@
`include "substring_highlight_segmenter_unit_macros.svh"

module shs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [shs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [7:0]                     s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [31:0]                    m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled result beat holds its payload.
  `SHS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // Segments are never empty.
  `SHS_ASSERT_IMPLIES(a_len_nonzero, m_axis_tvalid, m_axis_tdata[31:16] != 16'd0)

  // The last segment of a line is also the last beat of its byte.
  `SHS_ASSERT_IMPLIES(a_final_is_last, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1])

  // A match is no longer than the longest pattern length code.
  `SHS_ASSERT_IMPLIES(a_match_len, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:21] == 11'd0)

endmodule

bind substring_highlight_segmenter_unit shs_checker u_shs_checker (.*);

@@ bench/substring_highlight_segmenter_unit_checker.sv @@
`timescale 1ns / 100ps

module substring_highlight_segmenter_unit_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  logic                           s_axis_tlast,   // line_end
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [31:0]                    m_axis_tdata,   // [15:0] start, [31:16] length
  input  logic [1:0]                     m_axis_tuser,   // [0] is_match, [1] last
  input  logic                           m_axis_tlast,   // line_final
  output int unsigned                    mismatches,
  output int unsigned                    outstanding,
  output int unsigned                    segments_checked
);

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic        is_match;
    logic        line_final;
    logic        last_of_byte;
  } segment_t;

  segment_t segments_due[$];
  segment_t byte_segments[3];
  int unsigned byte_seg_count;

  // register copies
  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  pat_len;
  logic        exact, word_mode, enabled;

  // line state
  logic [7:0]  window [0:16];
  int unsigned line_pos, search_from, seg_begin, held_start;
  logic        held_valid;

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] lowered(input logic [7:0] c);
    if (!exact && c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned j);
    if (j < 8) begin
      return pat_lo[8*j +: 8];
    end
    return pat_hi[8*(j-8) +: 8];
  endfunction

  function automatic logic [15:0] sat16(input int unsigned v);
    return (v > 32'd65535) ? 16'hffff : v[15:0];
  endfunction

  task automatic restart_line();
    int unsigned k;
    for (k = 0; k <= 16; k++) begin
      window[k] = 8'h00;
    end
    line_pos    = 0;
    search_from = 0;
    seg_begin   = 0;
    held_valid  = 1'b0;
    held_start  = 0;
  endtask

  task automatic add_segment(input int unsigned from, input int unsigned count,
                             input logic m);
    if (byte_seg_count < 3 && count != 0) begin
      byte_segments[byte_seg_count].start        = sat16(from);
      byte_segments[byte_seg_count].length       = sat16(count);
      byte_segments[byte_seg_count].is_match     = m;
      byte_segments[byte_seg_count].line_final   = 1'b0;
      byte_segments[byte_seg_count].last_of_byte = 1'b0;
      byte_seg_count++;
    end
  endtask

  task automatic add_match(input int unsigned p, input int unsigned n);
    if (p > seg_begin) begin
      add_segment(seg_begin, p - seg_begin, 1'b0);
    end
    add_segment(p, n, 1'b1);
    seg_begin = p + n;
  endtask

  // Segments one text byte and, while the search is enabled, queues the resulting segments.
  task automatic segment_byte(input logic [7:0] c, input logic eol);
    int unsigned n, i, p, stop, k;
    logic hit, left_ok;
    n = (pat_len == 0) ? 1 : ((pat_len > 16) ? 16 : pat_len);
    i = line_pos;
    byte_seg_count = 0;
    for (k = 16; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = c;

    // whole-word candidate waiting for its right neighbor
    if (held_valid) begin
      if (!word_char(c)) begin
        add_match(held_start, n);
      end
      held_valid = 1'b0;
    end

    if (i < shs_pkg::MAX_LINE && i + 1 >= n) begin
      p = i + 1 - n;
      if (p >= search_from) begin
        hit = 1'b1;
        for (k = 0; k < n; k++) begin
          if (lowered(window[n-1-k]) != lowered(pat_byte(k))) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          // a rejected whole-word candidate still moves the search on
          search_from = p + n;
          if (word_mode) begin
            left_ok = (p == 0) || !word_char(window[n]);
            if (left_ok) begin
              if (eol) begin
                add_match(p, n);
              end else begin
                held_valid = 1'b1;
                held_start = p;
              end
            end
          end else begin
            add_match(p, n);
          end
        end
      end
    end

    if (eol) begin
      stop = (i + 1 > shs_pkg::MAX_LINE) ? shs_pkg::MAX_LINE : i + 1;
      if (stop > seg_begin) begin
        add_segment(seg_begin, stop - seg_begin, 1'b0);
      end
      if (byte_seg_count > 0) begin
        byte_segments[byte_seg_count-1].line_final = 1'b1;
      end
      restart_line();
    end else begin
      line_pos = (i < shs_pkg::MAX_LINE) ? i + 1 : shs_pkg::MAX_LINE;
    end

    if (enabled) begin
      if (byte_seg_count > 0) begin
        byte_segments[byte_seg_count-1].last_of_byte = 1'b1;
      end
      for (k = 0; k < byte_seg_count; k++) begin
        segments_due.push_back(byte_segments[k]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t seen, want;
    if (!rst_ni) begin
      pat_lo    = '0;
      pat_hi    = '0;
      pat_len   = 5'd1;
      exact     = 1'b0;
      word_mode = 1'b0;
      enabled   = 1'b1;
      restart_line();
      segments_due.delete();
      mismatches       = 0;
      outstanding      = 0;
      segments_checked = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.start        = m_axis_tdata[15:0];
        seen.length       = m_axis_tdata[31:16];
        seen.is_match     = m_axis_tuser[0];
        seen.last_of_byte = m_axis_tuser[1];
        seen.line_final   = m_axis_tlast;
        if (segments_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected segment, actual start=%0d len=%0d match=%0b final=%0b last=%0b",
                   $time, seen.start, seen.length, seen.is_match, seen.line_final,
                   seen.last_of_byte);
        end else begin
          want = segments_due.pop_front();
          segments_checked++;
          if (seen !== want) begin
            mismatches++;
            $display({"%0t: segment mismatch, expected start=%0d len=%0d match=%0b final=%0b",
                      " last=%0b, actual start=%0d len=%0d match=%0b final=%0b last=%0b"},
                     $time, want.start, want.length, want.is_match, want.line_final,
                     want.last_of_byte, seen.start, seen.length, seen.is_match,
                     seen.line_final, seen.last_of_byte);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        segment_byte(s_axis_tdata, s_axis_tlast);
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          shs_pkg::CFG_PAT_LO:  pat_lo    = cfg_data_i;
          shs_pkg::CFG_PAT_HI:  pat_hi    = cfg_data_i;
          shs_pkg::CFG_PAT_LEN: pat_len   = cfg_data_i[4:0];
          shs_pkg::CFG_CASE:    exact     = cfg_data_i[0];
          shs_pkg::CFG_WORD:    word_mode = cfg_data_i[0];
          shs_pkg::CFG_ENABLE:  enabled   = cfg_data_i[0];
          default: ;
        endcase
      end

      outstanding = segments_due.size();
    end
  end

endmodule

@@ bench/substring_highlight_segmenter_unit_test.sv @@
`timescale 1ns / 100ps

module substring_highlight_segmenter_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_LINE    = 65540;
  localparam int unsigned RANDOM_SETS  = 6;
  localparam int unsigned SET_BYTES    = 22;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // [7:0] text_byte
  logic                           s_axis_tlast = 1'b0; // line_end
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;        // [15:0] start, [31:16] length
  logic [1:0]                     m_axis_tuser;        // [0] is_match, [1] last
  logic                           m_axis_tlast;        // line_final

  int unsigned mismatches, outstanding, segments_checked;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 0;
  logic        calm = 1'b0;

  // copy of the current pattern, used to build lines that hit it
  logic [7:0]  pat_text [0:15];
  int unsigned use_len = 1;
  logic [7:0]  line_buf[$];

  substring_highlight_segmenter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  substring_highlight_segmenter_unit_checker segment_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .segments_checked (segments_checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result sink: random stall bursts while not calm
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && !calm && $urandom_range(0, 7) == 0) begin
      sink_hold     <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  task automatic put_reg(input shs_pkg::cfg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] n, input logic cs, input logic ww,
                           input logic en);
    int unsigned k;
    put_reg(shs_pkg::CFG_PAT_LO, lo);
    put_reg(shs_pkg::CFG_PAT_HI, hi);
    put_reg(shs_pkg::CFG_PAT_LEN, 64'(n));
    put_reg(shs_pkg::CFG_CASE, 64'(cs));
    put_reg(shs_pkg::CFG_WORD, 64'(ww));
    put_reg(shs_pkg::CFG_ENABLE, 64'(en));
    cfg_valid_i <= 1'b0;
    for (k = 0; k < 16; k++) begin
      pat_text[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
    end
    use_len = (n == 0) ? 1 : ((n > 16) ? 16 : n);
    settings_used++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eol);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_byte(s[k], close && (k == s.len() - 1));
    end
  endtask

  task automatic send_line();
    int k;
    for (k = 0; k < line_buf.size(); k++) begin
      send_byte(line_buf[k], k == line_buf.size() - 1);
    end
  endtask

  // wait for every expected segment, then for the pipeline to go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] w;
    int k;
    w = '0;
    for (k = 0; k < s.len() && k < 8; k++) begin
      w[8*k +: 8] = s[k];
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_char();
    string alphabet;
    alphabet = "aAbB 1.-Zz";
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  task automatic random_setting();
    logic [63:0] lo, hi;
    logic [4:0]  n;
    int unsigned k, r;
    for (k = 0; k < 16; k++) begin
      if (k < 8) begin
        lo[8*k +: 8] = pick_char();
      end else begin
        hi[8*(k-8) +: 8] = pick_char();
      end
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      n = 5'($urandom_range(1, 4));
    end else if (r < 8) begin
      n = 5'($urandom_range(5, 16));
    end else if (r == 8) begin
      n = 5'd0;
    end else begin
      n = 5'($urandom_range(17, 31));
    end
    configure(lo, hi, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 5) != 0);
  endtask

  // mostly pattern copies between separators, sometimes raw noise
  task automatic random_line();
    int unsigned target, k, cut;
    logic [7:0] b;
    string seps;
    seps = " ,.x1";
    line_buf.delete();
    target = $urandom_range(1, 14);
    if ($urandom_range(0, 6) == 0) begin
      for (k = 0; k < target; k++) begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      while (line_buf.size() < target) begin
        case ($urandom_range(0, 4))
          0, 1, 2: begin
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, use_len) : use_len;
            for (k = 0; k < cut; k++) begin
              b = pat_text[k];
              if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(0, 3) == 0) begin
                b = b ^ 8'h20;
              end
              line_buf.push_back(b);
            end
          end
          default: line_buf.push_back(seps[$urandom_range(0, seps.len() - 1)]);
        endcase
      end
    end
    send_line();
  endtask

  initial begin
    int unsigned k, set_start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern is a single zero byte
    line_buf = '{8'h00, 8'h7f, 8'h00};
    send_line();
    settle();

    // case folding, leftmost non-overlapping, single-byte line
    configure(pack_text("aB"), '0, 5'd2, 1'b0, 1'b0, 1'b1);
    send_text("xAbab", 1'b1);
    send_text("q", 1'b1);
    settle();

    // whole word: match at line start, right side fails, match ending the line
    configure(pack_text("ab"), '0, 5'd2, 1'b1, 1'b1, 1'b1);
    send_text("ab+abc ab", 1'b1);
    // pattern length changes while a candidate waits for its right side
    send_text(" ab", 1'b0);
    settle();
    configure(pack_text("ab"), '0, 5'd3, 1'b1, 1'b1, 1'b1);
    send_text("-", 1'b1);
    settle();

    configure(pack_text("ab"), '0, 5'd2, 1'b1, 1'b1, 1'b0);
    send_text("ab", 1'b1);
    settle();

    // length zero acts as one
    configure(pack_text("z"), '1, 5'd0, 1'b0, 1'b0, 1'b1);
    send_text("zZ", 1'b1);
    settle();

    // length above the maximum clamps to sixteen
    configure('1, '1, 5'd31, 1'b1, 1'b0, 1'b1);
    line_buf.delete();
    for (k = 0; k < 16; k++) begin
      line_buf.push_back(8'hff);
    end
    send_line();
    settle();

    // bytes above 0x7f are never folded
    configure(64'h51c1, '0, 5'd2, 1'b0, 1'b0, 1'b1);
    line_buf = '{8'he1, "q", 8'hc1, "q"};
    send_line();
    settle();

    // line longer than the position range: a match just below saturation,
    // the same text at the saturated offset is not found
    calm = 1'b1;
    configure(pack_text("ab"), '0, 5'd2, 1'b0, 1'b0, 1'b1);
    for (k = 0; k < LONG_LINE; k++) begin
      if (k == 65533 || k == 65535) begin
        send_byte("a", 1'b0);
      end else if (k == 65534 || k == 65536) begin
        send_byte("b", 1'b0);
      end else begin
        send_byte(".", k == LONG_LINE - 1);
      end
    end
    settle();

    for (k = 0; k < RANDOM_SETS; k++) begin
      calm = (k == RANDOM_SETS - 1);
      random_setting();
      set_start = bytes_sent;
      while (bytes_sent - set_start < SET_BYTES) begin
        random_line();
      end
      settle();
    end

    $display("Checked %0d segments from %0d text bytes under %0d register settings:",
             segments_checked, bytes_sent, settings_used);
    $display("folding, whole-word rules, disabled search, length clamps, long-line limit.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/shs_pkg.sv
rtl/shs_front.sv
rtl/shs_queue.sv
rtl/shs_back.sv
rtl/substring_highlight_segmenter_unit.sv
rtl/shs_checker.sv
bench/substring_highlight_segmenter_unit_checker.sv
bench/substring_highlight_segmenter_unit_test.sv
